// ===== src/spi_drive_command_receiver_macros.svh =====
// Assertion macros for the SPI drive command receiver.
// Included by the top level; no other dependencies.
`ifndef SPI_DRIVE_COMMAND_RECEIVER_MACROS_SVH
`define SPI_DRIVE_COMMAND_RECEIVER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SDCR_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("sdcr assertion failed");

// Next-cycle implication.
`define SDCR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("sdcr assertion failed");

`endif

// ===== src/sdcr_pkg.sv =====
// Shared types and constants for the SPI drive command receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sdcr_pkg;

	// input kinds as they arrive on tuser
	localparam logic [1:0] CMD_BYTE = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_STOP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx;
	} item_t;

	// packed so that tx_byte sits in the low bits
	typedef struct packed {
		logic        halted;
		logic        frame_ok;
		logic [15:0] steer_compare;
		logic [15:0] speed_compare;
		logic [7:0]  tx_byte;
	} result_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;

	typedef struct packed {
		logic                   valid;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} cfg_wr_t;

	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_NEUTRAL = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_RATE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEER_NEUTRAL = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STEER_RATE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_OFFSET  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 3'd6;

	localparam logic [15:0] RST_SPEED_NEUTRAL = 16'd18510;
	localparam logic [7:0]  RST_SPEED_RATE    = 8'd2;
	localparam logic [15:0] RST_STEER_NEUTRAL = 16'd18570;
	localparam logic [7:0]  RST_STEER_RATE    = 8'd4;
	localparam logic [6:0]  RST_SPEED_LIMIT   = 7'd30;
	localparam logic [4:0]  RST_SPEED_OFFSET  = 5'd20;
	localparam logic [16:0] RST_TIMEOUT_TICKS = 17'd65536;
	localparam logic [7:0]  RST_ANGLE_BYTE    = 8'h11;

	localparam logic [7:0] BYTE_START  = 8'hAA;
	localparam logic [7:0] BYTE_FINISH = 8'h66;
	localparam logic [7:0] TX_WAITING  = 8'hEE;
	localparam logic [7:0] TX_NONE     = 8'h00;

	// speed shaping knees, 10-bit signed working width
	localparam logic signed [9:0] SPEED_KNEE_POS = 10'sd108;
	localparam logic signed [9:0] SPEED_KNEE_NEG = -10'sd109;
	localparam logic signed [9:0] SPEED_MAX      = 10'sd127;
	localparam logic signed [9:0] SPEED_MIN      = -10'sd128;

endpackage

// ===== src/sdcr_front.sv =====
// Front end: accepts input beats, decodes the command kind and queues them.
// Depends on sdcr_pkg.
`timescale 1ns / 1ps

module sdcr_front #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,
	input  logic [1:0]     s_tuser,
	output logic           q_valid,
	output sdcr_pkg::item_t q_item,
	input  logic           q_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sdcr_pkg::item_t      entry_q [DEPTH];
	sdcr_pkg::item_t      dec;
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 push;

	always_comb begin
		dec.rx = s_tdata;
		case (s_tuser)
			sdcr_pkg::CMD_BYTE: dec.op = sdcr_pkg::OP_BYTE;
			sdcr_pkg::CMD_TICK: dec.op = sdcr_pkg::OP_TICK;
			sdcr_pkg::CMD_STOP: dec.op = sdcr_pkg::OP_STOP;
			default:            dec.op = sdcr_pkg::OP_NONE;
		endcase
	end

	assign s_tready = (count_q < CW'(DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/sdcr_back.sv =====
// Back end: configuration registers, frame sequencer, compare math, output register.
// Depends on sdcr_pkg.
`timescale 1ns / 1ps

module sdcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sdcr_pkg::cfg_wr_t cfg,
	input  logic              q_valid,
	input  sdcr_pkg::item_t   q_item,
	output logic              q_pop,
	output logic              out_valid,
	output sdcr_pkg::result_t out_res,
	input  logic              out_ready
);

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_SPEED,
		PH_ANGLE,
		PH_ECHO,
		PH_FINISH
	} phase_t;

	// configuration
	logic [15:0] speed_neutral_q, steer_neutral_q;
	logic [7:0]  speed_rate_q, steer_rate_q;
	logic [6:0]  speed_limit_q;
	logic [4:0]  speed_offset_q;
	logic [16:0] timeout_ticks_q;

	// sequencer state
	phase_t      phase_q, phase_d;
	logic [7:0]  speed_byte_q, speed_byte_d, angle_byte_q, angle_byte_d;
	logic [16:0] tick_q, tick_d, tick_inc, tick_lim;
	logic        stopped_q, stopped_d, ok_d;
	logic [15:0] speed_val_q, speed_val_d, steer_val_q, steer_val_d;
	logic [7:0]  tx_d;
	logic        out_valid_q;
	sdcr_pkg::result_t out_q;

	// compare math
	logic signed [9:0]  s_raw, s_lim, s_off, s_cl, s_adj, s_sat;
	logic signed [7:0]  s_fin;
	logic signed [16:0] speed_prod, steer_prod;
	logic [15:0]        speed_new, steer_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_neutral_q <= sdcr_pkg::RST_SPEED_NEUTRAL;
			speed_rate_q    <= sdcr_pkg::RST_SPEED_RATE;
			steer_neutral_q <= sdcr_pkg::RST_STEER_NEUTRAL;
			steer_rate_q    <= sdcr_pkg::RST_STEER_RATE;
			speed_limit_q   <= sdcr_pkg::RST_SPEED_LIMIT;
			speed_offset_q  <= sdcr_pkg::RST_SPEED_OFFSET;
			timeout_ticks_q <= sdcr_pkg::RST_TIMEOUT_TICKS;
		end else if (cfg.valid) begin
			case (cfg.index)
				sdcr_pkg::REG_SPEED_NEUTRAL: speed_neutral_q <= cfg.data[15:0];
				sdcr_pkg::REG_SPEED_RATE:    speed_rate_q    <= cfg.data[7:0];
				sdcr_pkg::REG_STEER_NEUTRAL: steer_neutral_q <= cfg.data[15:0];
				sdcr_pkg::REG_STEER_RATE:    steer_rate_q    <= cfg.data[7:0];
				sdcr_pkg::REG_SPEED_LIMIT:   speed_limit_q   <= cfg.data[6:0];
				sdcr_pkg::REG_SPEED_OFFSET:  speed_offset_q  <= cfg.data[4:0];
				sdcr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg.data[16:0];
				default: ;
			endcase
		end
	end

	// clamp, dead-band offset, saturate
	always_comb begin
		s_raw = $signed({{2{speed_byte_q[7]}}, speed_byte_q});
		s_lim = $signed({3'b000, speed_limit_q});
		s_off = $signed({5'b00000, speed_offset_q});
		if (s_raw > s_lim) begin
			s_cl = s_lim;
		end else if (s_raw < -s_lim) begin
			s_cl = -s_lim;
		end else begin
			s_cl = s_raw;
		end
		if (s_cl > 10'sd0) begin
			s_adj = (s_cl < sdcr_pkg::SPEED_KNEE_POS) ? s_cl + s_off : sdcr_pkg::SPEED_MAX;
		end else if (s_cl < 10'sd0) begin
			s_adj = (s_cl > sdcr_pkg::SPEED_KNEE_NEG) ? s_cl - s_off : sdcr_pkg::SPEED_MIN;
		end else begin
			s_adj = s_cl;
		end
		if (s_adj > sdcr_pkg::SPEED_MAX) begin
			s_sat = sdcr_pkg::SPEED_MAX;
		end else if (s_adj < sdcr_pkg::SPEED_MIN) begin
			s_sat = sdcr_pkg::SPEED_MIN;
		end else begin
			s_sat = s_adj;
		end
		s_fin      = s_sat[7:0];
		speed_prod = s_fin * $signed({1'b0, speed_rate_q});
		steer_prod = $signed(angle_byte_q) * $signed({1'b0, steer_rate_q});
		speed_new  = speed_neutral_q - speed_prod[15:0];
		steer_new  = steer_neutral_q - steer_prod[15:0];
	end

	assign tick_inc = tick_q + 17'd1;
	assign tick_lim = (timeout_ticks_q == '0) ? 17'd1 : timeout_ticks_q;

	always_comb begin
		phase_d      = phase_q;
		speed_byte_d = speed_byte_q;
		angle_byte_d = angle_byte_q;
		tick_d       = tick_q;
		stopped_d    = stopped_q;
		speed_val_d  = speed_val_q;
		steer_val_d  = steer_val_q;
		ok_d         = 1'b0;
		if (!stopped_q) begin
			case (q_item.op)
				sdcr_pkg::OP_BYTE: begin
					case (phase_q)
						PH_SPEED: begin
							speed_byte_d = q_item.rx;
							phase_d      = PH_ANGLE;
						end
						PH_ANGLE: begin
							angle_byte_d = q_item.rx;
							phase_d      = PH_ECHO;
						end
						PH_ECHO: phase_d = PH_FINISH;
						PH_FINISH: begin
							if (q_item.rx == sdcr_pkg::BYTE_FINISH) begin
								speed_val_d = speed_new;
								steer_val_d = steer_new;
								tick_d      = '0;
								ok_d        = 1'b1;
							end
							phase_d = PH_WAIT;
						end
						default: begin
							phase_d = (q_item.rx == sdcr_pkg::BYTE_START) ? PH_SPEED : PH_WAIT;
						end
					endcase
				end
				sdcr_pkg::OP_TICK: begin
					if (tick_inc >= tick_lim) begin
						tick_d      = '0;
						speed_val_d = speed_neutral_q;
						steer_val_d = steer_neutral_q;
					end else begin
						tick_d = tick_inc;
					end
				end
				sdcr_pkg::OP_STOP: begin
					stopped_d   = 1'b1;
					speed_val_d = speed_neutral_q;
					steer_val_d = steer_neutral_q;
				end
				default: ;
			endcase
		end
		case (phase_d)
			PH_WAIT: tx_d = sdcr_pkg::TX_WAITING;
			PH_ECHO: tx_d = speed_byte_d ^ angle_byte_d;
			default: tx_d = sdcr_pkg::TX_NONE;
		endcase
	end

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			speed_byte_q <= '0;
			angle_byte_q <= sdcr_pkg::RST_ANGLE_BYTE;
			tick_q       <= '0;
			stopped_q    <= 1'b0;
			speed_val_q  <= sdcr_pkg::RST_SPEED_NEUTRAL;
			steer_val_q  <= sdcr_pkg::RST_STEER_NEUTRAL;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else if (q_pop) begin
			phase_q              <= phase_d;
			speed_byte_q         <= speed_byte_d;
			angle_byte_q         <= angle_byte_d;
			tick_q               <= tick_d;
			stopped_q            <= stopped_d;
			speed_val_q          <= speed_val_d;
			steer_val_q          <= steer_val_d;
			out_valid_q          <= 1'b1;
			out_q.tx_byte        <= tx_d;
			out_q.speed_compare  <= speed_val_d;
			out_q.steer_compare  <= steer_val_d;
			out_q.frame_ok       <= ok_d;
			out_q.halted         <= stopped_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== src/spi_drive_command_receiver.sv =====
// Top level of the SPI drive command receiver: front queue, back sequencer, ports.
// Depends on sdcr_pkg, sdcr_front, sdcr_back and the assertion macro header.
//
// Usage:
//   s_* carries one beat per SPI event: tuser is the kind (0 byte received,
//   1 timer tick, 2 stop, 3 ignored), tdata the received byte.
//   m_* returns exactly one beat per input beat: the byte to load for the
//   next transfer, both PWM compare values, a good-frame flag and the halt flag.
//   cfg_* writes register cfg_index (0 speed neutral, 1 speed rate, 2 steer
//   neutral, 3 steer rate, 4 speed limit, 5 speed offset, 6 timeout ticks);
//   it is always ready and should be used only while no beat is in flight.
// Timing:
//   m_tvalid rises once an accepted beat has passed the front queue and the
//   output register; it is taken on an edge with m_tready high. Throughput is
//   one beat per cycle while m_tready stays high, set by the back-end sequencer.
// Reset:
//   arst_n clears the queue, empties the output register, loads the register
//   defaults and puts both compares at their neutral defaults.
// Stall:
//   With m_tready low the output register holds its beat; the front queue
//   (QUEUE_DEPTH beats) keeps taking input until full, then drops s_tready.
`timescale 1ns / 1ps
`include "spi_drive_command_receiver_macros.svh"

module spi_drive_command_receiver #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] tx_byte, [23:8] speed_compare,
	                               // [39:24] steer_compare, [40] frame_ok,
	                               // [41] halted, [47:42] zero
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	sdcr_pkg::item_t   q_item;
	logic              q_valid, q_pop;
	sdcr_pkg::cfg_wr_t cfg;
	sdcr_pkg::result_t res;

	// register file never stalls a write
	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	sdcr_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	sdcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_res   (res),
		.out_ready (m_tready)
	);

	assign m_tdata = {6'b000000, res};

	// a completed frame always returns the sequencer to waiting for start
	`SDCR_ASSERT_IMPLIES(a_ok_tx_wait, clk, arst_n, m_tvalid && res.frame_ok,
		res.tx_byte == sdcr_pkg::TX_WAITING)
	// no frame can complete once halted
	`SDCR_ASSERT_IMPLIES(a_ok_not_halted, clk, arst_n, m_tvalid && res.frame_ok,
		!res.halted)
	// halt is sticky across delivered beats
	`SDCR_ASSERT_NEXT(a_halt_sticky, clk, arst_n, m_tvalid && m_tready && res.halted,
		!m_tvalid || res.halted)

endmodule

// ===== dv/spi_drive_command_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the SPI drive command receiver: watches the input, result
// and register write channels, predicts every result beat and compares fields.
// Depends on sdcr_pkg for the beat layouts, register indexes and defaults.

module spi_drive_command_checker
	import sdcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output int          fail_count,
	output int          in_flight
);

	typedef enum logic [2:0] {
		AWAIT_START,
		TAKE_SPEED,
		TAKE_ANGLE,
		SKIP_ECHO,
		CHECK_FINISH
	} frame_step_t;

	// register copies
	logic [15:0] speed_neutral, steer_neutral;
	logic [7:0]  speed_rate, steer_rate;
	logic [6:0]  speed_limit;
	logic [4:0]  speed_offset;
	logic [16:0] timeout_ticks;

	// frame state
	frame_step_t step;
	logic [7:0]  speed_byte, angle_byte;
	logic [16:0] tick_count;
	logic        frozen;
	logic [15:0] speed_cmp, steer_cmp;

	result_t due_status[$];
	result_t want;
	int      mismatches = 0;
	int      waiting = 0;

	assign fail_count = mismatches;
	assign in_flight  = waiting;

	function automatic void recompute_compares();
		int s, a, lim, off;
		s   = int'($signed(speed_byte));
		a   = int'($signed(angle_byte));
		lim = int'(speed_limit);
		off = int'(speed_offset);
		if (s > lim)
			s = lim;
		else if (s < -lim)
			s = -lim;
		// dead band: push nonzero speed away from zero, snap past the knees
		if (s > 0)
			s = (s < int'(SPEED_KNEE_POS)) ? s + off : int'(SPEED_MAX);
		else if (s < 0)
			s = (s > int'(SPEED_KNEE_NEG)) ? s - off : int'(SPEED_MIN);
		if (s > int'(SPEED_MAX))
			s = int'(SPEED_MAX);
		if (s < int'(SPEED_MIN))
			s = int'(SPEED_MIN);
		speed_cmp = 16'(int'(speed_neutral) - s * int'(speed_rate));
		steer_cmp = 16'(int'(steer_neutral) - a * int'(steer_rate));
	endfunction

	function automatic result_t predict_drive_beat(input op_t op, input logic [7:0] rx);
		result_t     r;
		logic [16:0] tick_lim;
		r = '0;
		if (!frozen) begin
			case (op)
				OP_BYTE: begin
					case (step)
						TAKE_SPEED: begin
							speed_byte = rx;
							step = TAKE_ANGLE;
						end
						TAKE_ANGLE: begin
							angle_byte = rx;
							step = SKIP_ECHO;
						end
						SKIP_ECHO: step = CHECK_FINISH;
						CHECK_FINISH: begin
							if (rx == BYTE_FINISH) begin
								recompute_compares();
								tick_count = '0;
								r.frame_ok = 1'b1;
							end
							step = AWAIT_START;
						end
						default: step = (rx == BYTE_START) ? TAKE_SPEED : AWAIT_START;
					endcase
				end
				OP_TICK: begin
					tick_lim = (timeout_ticks == '0) ? 17'd1 : timeout_ticks;
					tick_count = tick_count + 17'd1;
					if (tick_count >= tick_lim) begin
						tick_count = '0;
						speed_cmp = speed_neutral;
						steer_cmp = steer_neutral;
					end
				end
				OP_STOP: begin
					frozen = 1'b1;
					speed_cmp = speed_neutral;
					steer_cmp = steer_neutral;
				end
				default: ;
			endcase
		end
		case (step)
			AWAIT_START: r.tx_byte = TX_WAITING;
			SKIP_ECHO:   r.tx_byte = speed_byte ^ angle_byte;
			default:     r.tx_byte = TX_NONE;
		endcase
		r.speed_compare = speed_cmp;
		r.steer_compare = steer_cmp;
		r.halted = frozen;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			mismatches++;
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_neutral = RST_SPEED_NEUTRAL;
			speed_rate    = RST_SPEED_RATE;
			steer_neutral = RST_STEER_NEUTRAL;
			steer_rate    = RST_STEER_RATE;
			speed_limit   = RST_SPEED_LIMIT;
			speed_offset  = RST_SPEED_OFFSET;
			timeout_ticks = RST_TIMEOUT_TICKS;
			step          = AWAIT_START;
			speed_byte    = '0;
			angle_byte    = RST_ANGLE_BYTE;
			tick_count    = '0;
			frozen        = 1'b0;
			speed_cmp     = RST_SPEED_NEUTRAL;
			steer_cmp     = RST_STEER_NEUTRAL;
			due_status.delete();
		end else begin
			// result side first: a beat leaving now belongs to an older input
			if (m_tvalid && m_tready) begin
				if (due_status.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none got %h", $time, m_tdata);
				end else begin
					want = due_status.pop_front();
					check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
					check_field("speed_compare", want.speed_compare, m_tdata[23:8]);
					check_field("steer_compare", want.steer_compare, m_tdata[39:24]);
					check_field("frame_ok", want.frame_ok, m_tdata[40]);
					check_field("halted", want.halted, m_tdata[41]);
					check_field("tdata pad", 0, m_tdata[47:42]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SPEED_NEUTRAL: speed_neutral = cfg_data[15:0];
					REG_SPEED_RATE:    speed_rate    = cfg_data[7:0];
					REG_STEER_NEUTRAL: steer_neutral = cfg_data[15:0];
					REG_STEER_RATE:    steer_rate    = cfg_data[7:0];
					REG_SPEED_LIMIT:   speed_limit   = cfg_data[6:0];
					REG_SPEED_OFFSET:  speed_offset  = cfg_data[4:0];
					REG_TIMEOUT_TICKS: timeout_ticks = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				due_status.push_back(predict_drive_beat(op_t'(s_tuser), s_tdata));
		end
		waiting = due_status.size();
	end

endmodule

// ===== dv/spi_drive_command_receiver_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the SPI drive command receiver: clock, reset, register
// setup and beat stimulus; checking is done by spi_drive_command_checker.
// Depends on sdcr_pkg, spi_drive_command_receiver and the checker.

module spi_drive_command_receiver_tb;
	import sdcr_pkg::*;

	localparam int WATCHDOG_NS = 5_000_000;   // far above the slowest clean run
	localparam int PHASE_BEATS = 230;         // counted input beats per random phase

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;

	int fail_count;
	int in_flight;
	int src_idle_pct = 0;    // chance per cycle that the sender holds back
	int snk_stall_pct = 0;   // chance per cycle that the receiver stalls
	int beats_sent = 0;
	int cur_limit = 30;      // speed limit now in the block, to aim speeds at the clamp

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	spi_drive_command_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	spi_drive_command_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	// receiver backpressure, redrawn every cycle
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// 0: free running, 1: sender gaps, 2: receiver stalls, 3: both, lighter
	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				src_idle_pct = 64;
				snk_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				snk_stall_pct = 64;
			end
			3: begin
				src_idle_pct = 27;
				snk_stall_pct = 27;
			end
			default: begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
		endcase
	endtask

	// Called and returns at a falling edge. tvalid stays high across
	// back-to-back beats; only a gap lowers it.
	task automatic push_item(input op_t op, input logic [7:0] rx);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= rx;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// writes the whole register set back to back, only while nothing is in flight
	task automatic program_regs(input logic [15:0] sn, input logic [7:0] sr,
			input logic [15:0] tn, input logic [7:0] tr, input logic [6:0] lim,
			input logic [4:0] off, input logic [16:0] tmo);
		put_reg(REG_SPEED_NEUTRAL, 17'(sn));
		put_reg(REG_SPEED_RATE, 17'(sr));
		put_reg(REG_STEER_NEUTRAL, 17'(tn));
		put_reg(REG_STEER_RATE, 17'(tr));
		put_reg(REG_SPEED_LIMIT, 17'(lim));
		put_reg(REG_SPEED_OFFSET, 17'(off));
		put_reg(REG_TIMEOUT_TICKS, tmo);
		cfg_valid <= 1'b0;
		cur_limit = int'(lim);
	endtask

	// sender goes quiet, waits until all results are back, then lets the pipe settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// speed bytes aimed at the clamp edges and the dead-band knees
	function automatic logic [7:0] pick_speed();
		case ($urandom_range(0, 7))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'(cur_limit + $urandom_range(0, 2) - 1);
			3: return 8'(-cur_limit + $urandom_range(0, 2) - 1);
			4: return 8'(107 + $urandom_range(0, 2));
			5: return 8'(-108 - $urandom_range(0, 2));
			6: return 8'($urandom_range(0, 2) - 1);
			default: return 8'($urandom);
		endcase
	endfunction

	// Start, speed, angle, echo slot, finish. Ticks may land between bytes;
	// some frames carry a bad finish or are cut short.
	task automatic send_frame();
		logic [7:0] fb[5];
		int         cut;
		fb[0] = BYTE_START;
		fb[1] = pick_speed();
		fb[2] = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'h7F : 8'h80)
			: 8'($urandom);
		fb[3] = 8'($urandom);
		fb[4] = ($urandom_range(0, 6) == 0) ? 8'($urandom) : BYTE_FINISH;
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4) : 5;
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_item(OP_TICK, 8'($urandom));
			push_item(OP_BYTE, fb[i]);
		end
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: push_item(OP_BYTE, 8'($urandom));
			1: push_item(OP_BYTE, BYTE_START);   // opens a frame that noise then breaks
			2: push_item(OP_TICK, 8'($urandom));
			default: push_item(OP_NONE, 8'($urandom));
		endcase
	endtask

	initial begin
		int target;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: full speed range reachable, short timeout.
		set_idling(0);
		program_regs(RST_SPEED_NEUTRAL, RST_SPEED_RATE, RST_STEER_NEUTRAL, RST_STEER_RATE,
			7'd127, RST_SPEED_OFFSET, 17'd3);
		// top speed past the knee, most negative angle
		push_item(OP_BYTE, BYTE_START);
		push_item(OP_BYTE, 8'h7F);
		push_item(OP_BYTE, 8'h80);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_BYTE, BYTE_FINISH);
		// bad finish byte: no update
		push_item(OP_BYTE, BYTE_START);
		push_item(OP_BYTE, 8'h80);
		push_item(OP_BYTE, 8'h7F);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_BYTE, 8'h65);
		// reverse right at the negative knee
		push_item(OP_BYTE, BYTE_START);
		push_item(OP_BYTE, 8'h93);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_BYTE, 8'h55);
		push_item(OP_BYTE, BYTE_FINISH);
		// zero speed gets no offset; a start byte in the echo slot is ignored
		push_item(OP_BYTE, BYTE_START);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_BYTE, BYTE_START);
		push_item(OP_BYTE, BYTE_FINISH);
		// three ticks reach the timeout and force neutral
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'hFF);
		push_item(OP_TICK, 8'h00);
		// unused code, then a non-start byte while waiting
		push_item(OP_NONE, 8'hFF);
		push_item(OP_BYTE, 8'hFF);

		// Random phases, each with its own register set and idling mode.
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: program_regs(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 7'd127, 5'd20, 17'd1);
				// timeout of zero behaves as one
				1: program_regs(16'h0000, 8'h00, 16'h0000, 8'h00, 7'd0, 5'd0, 17'd0);
				2: program_regs(RST_SPEED_NEUTRAL, RST_SPEED_RATE, RST_STEER_NEUTRAL,
					RST_STEER_RATE, RST_SPEED_LIMIT, RST_SPEED_OFFSET, RST_TIMEOUT_TICKS);
				default: program_regs(16'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom),
					($urandom_range(0, 3) == 0) ? 7'd127 : 7'($urandom_range(0, 127)),
					5'($urandom_range(0, 20)),
					($urandom_range(0, 4) == 0) ? 17'($urandom_range(1, 65536))
						: 17'($urandom_range(1, 10)));
			endcase
			set_idling(ph % 4);
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				if ($urandom_range(0, 99) < 80)
					send_frame();
				else
					send_noise();
			end
		end

		// Stop latches for good; everything after it must report frozen outputs.
		set_idling(3);
		push_item(OP_STOP, 8'($urandom));
		push_item(OP_BYTE, BYTE_START);
		push_item(OP_BYTE, 8'h10);
		push_item(OP_BYTE, 8'h20);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_BYTE, BYTE_FINISH);
		push_item(OP_TICK, 8'h00);
		push_item(OP_STOP, 8'h00);
		push_item(OP_NONE, 8'h00);

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog: a hang in either handshake ends the run here
	initial begin
		#(WATCHDOG_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
